/* sv/overtemp_alarm_with_threshold_adjust_macros.svh */
// Assertion macros for the over-temperature alarm block.
// Clocked on clk with an active-low reset; no other dependencies.
`ifndef OVERTEMP_ALARM_WITH_THRESHOLD_ADJUST_MACROS_SVH
`define OVERTEMP_ALARM_WITH_THRESHOLD_ADJUST_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset
`define OTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true out of reset
`define OTA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define OTA_ASSERT(lbl, prop, msg)
`define OTA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* sv/ota_pkg.sv */
// Shared constants, types and table functions for the over-temperature alarm.
// Used by the top level; the thermistor table is built here at elaboration.
package ota_pkg;

    localparam int ADC_BITS_DEFAULT = 10;

    localparam int FIELD_W     = 10;
    localparam int TEMP_RAW_W  = 10;
    localparam int THR_W       = 9;
    localparam int CENTI_W     = 17;
    localparam int STEP_W      = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_LOW  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_HIGH = 4'd1;

    localparam logic [FIELD_W-1:0] DEAD_LOW_RESET  = 10'd100;
    localparam logic [FIELD_W-1:0] DEAD_HIGH_RESET = 10'd900;

    // joystick step codes
    localparam logic signed [STEP_W-1:0] STEP_NONE     = 5'sd0;
    localparam logic signed [STEP_W-1:0] STEP_UP_ONE   = 5'sd1;
    localparam logic signed [STEP_W-1:0] STEP_DOWN_ONE = -5'sd1;
    localparam logic signed [STEP_W-1:0] STEP_DOWN_TEN = -5'sd10;
    localparam logic signed [STEP_W-1:0] STEP_UP_TEN   = 5'sd10;

    localparam logic signed [THR_W-1:0]   THR_MIN   = -9'sd55;
    localparam logic signed [THR_W-1:0]   THR_MAX   = 9'sd150;
    localparam logic signed [THR_W-1:0]   THR_RESET = 9'sd40;
    localparam logic signed [CENTI_W-1:0] CENTI_PER_DEG = 17'sd100;
    localparam logic signed [CENTI_W-1:0] THR_CENTI_RESET = 17'sd4000;

    localparam logic signed [CENTI_W-1:0] CENTI_ABS_ZERO = -17'sd27315;
    localparam logic signed [CENTI_W-1:0] CENTI_MAX      = 17'sd35500;

    localparam int          FRAC         = 30;
    localparam logic [63:0] LN2_Q30      = 64'd744261118;
    localparam logic [63:0] BETA_X100    = 64'd395000;
    localparam logic [63:0] T25_X100     = 64'd29815;
    localparam logic [63:0] ZERO_K_CENTI = 64'd27315;
    localparam logic [63:0] CENTI_TOP    = 64'd62815;   // 27315 + 35500

    // log2 of a small integer: integer part plus FRAC fraction bits
    function automatic logic [63:0] log2_fixed(input logic [63:0] v);
        logic [5:0]  e;
        logic [63:0] m;
        logic [63:0] res;
        e = 6'd0;
        for (int k = 1; k < 32; k++)
        begin
            if ((v >> k) != 64'd0)
                e = 6'(k);
        end
        m   = v << (FRAC - int'(e));
        res = 64'(e) << FRAC;
        for (int i = 1; i <= FRAC; i++)
        begin
            m = (m * m) >> FRAC;
            if (m >= (64'd2 << FRAC))
            begin
                m   = m >> 1;
                res = res | (64'd1 << (FRAC - i));
            end
        end
        return res;
    endfunction

    // shift-subtract quotient, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = 65'd0;
        q   = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // table entry for raw sample r: rounded centi-degrees from the beta equation
    function automatic logic signed [CENTI_W-1:0] temp_entry(input int unsigned r,
                                                             input int unsigned adc_bits);
        logic [63:0] fs;
        logic [63:0] la;
        logic [63:0] lb;
        logic [63:0] mag;
        logic [63:0] lnmag;
        logic [63:0] prod;
        logic [63:0] base;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] t;
        logic        neg;
        fs = (64'd1 << adc_bits) - 64'd1;
        if (r == 0 || 64'(r) >= fs)
            return CENTI_ABS_ZERO;
        la    = log2_fixed(64'(r));
        lb    = log2_fixed(fs - 64'(r));
        neg   = la < lb;
        mag   = neg ? (lb - la) : (la - lb);
        lnmag = ((mag >> 2) * LN2_Q30) >> (FRAC - 2);
        prod  = T25_X100 * lnmag;
        base  = BETA_X100 << FRAC;
        if (neg)
        begin
            if (prod >= base)
                return CENTI_MAX;
            d = base - prod;
        end
        else
        begin
            d = base + prod;
        end
        q = udiv64(((BETA_X100 * T25_X100) << FRAC) + (d >> 1), d);
        if (q > CENTI_TOP)
            return CENTI_MAX;
        t = q - ZERO_K_CENTI;
        return $signed(t[CENTI_W-1:0]);
    endfunction

endpackage

/* sv/ota_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ota_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/overtemp_alarm_with_threshold_adjust.sv */
// Over-temperature alarm with joystick threshold adjust: top level.
// Depends on ota_pkg, ota_ram and overtemp_alarm_with_threshold_adjust_macros.svh.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  s_*     | in  | s_tvalid / s_tready    | s_tdata: sensor samples, one item
//  m_*     | out | m_tvalid / m_tready    | m_tdata: mode, threshold, alarm, temp
//  cfg_*   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data: dead-band limits
//
// One item per cycle sustained while m_tready stays high. An accepted item is read
// from the table into the read stage; state update and output register load follow
// when the read stage advances. After reset the table RAM is loaded from the
// built-in beta table, one entry a cycle, while s_tready stays low; cfg is always
// taken. A stalled m_tready holds one result in the output register and one in the
// read stage; s_tready drops only when both are full or while the table loads.
module overtemp_alarm_with_threshold_adjust
    import ota_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // button_level[0], joy_x[10:1], joy_y[20:11], temp_raw[30:21], zero[31]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mode[0], threshold[9:1], alarm[10], temperature_centi[27:11], zero[31:28]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data
);

    `include "overtemp_alarm_with_threshold_adjust_macros.svh"

    localparam int DEPTH     = 1 << ADC_BITS;
    localparam int RAW_EXT_W = (ADC_BITS > TEMP_RAW_W) ? ADC_BITS : TEMP_RAW_W;

    // ---------------- built-in table and load sweep ----------------
    logic [CENTI_W-1:0] rom_table [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_rom
        localparam logic signed [CENTI_W-1:0] ENTRY = temp_entry(gi, ADC_BITS);
        assign rom_table[gi] = ENTRY;
    end

    logic [ADC_BITS:0]   fill_cnt_reg, fill_cnt_next;
    logic                wr_en_reg, wr_en_next;
    logic [ADC_BITS-1:0] wr_addr_reg;
    logic [CENTI_W-1:0]  wr_data_reg;
    logic                fill_active;
    logic                fill_done;

    assign fill_active = !fill_cnt_reg[ADC_BITS];
    assign fill_done   = !fill_active && !wr_en_reg;

    // ---------------- input unpack ----------------
    logic                 in_button;
    logic [FIELD_W-1:0]   in_joy_x;
    logic [FIELD_W-1:0]   in_joy_y;
    logic [TEMP_RAW_W-1:0] in_temp_raw;
    logic [RAW_EXT_W-1:0] raw_ext;
    logic [ADC_BITS-1:0]  rd_addr;
    logic                 in_accept;

    assign in_button   = s_tdata[0];
    assign in_joy_x    = s_tdata[10:1];
    assign in_joy_y    = s_tdata[20:11];
    assign in_temp_raw = s_tdata[30:21];
    assign raw_ext     = RAW_EXT_W'(in_temp_raw);
    assign rd_addr     = raw_ext[ADC_BITS-1:0];

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic s1_adv;

    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = fill_done && (!s1_valid_reg || s1_adv);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    logic [CENTI_W-1:0] ram_rdata;

    ota_ram #(
        .WIDTH(CENTI_W),
        .DEPTH(DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (wr_en_reg),
        .waddr(wr_addr_reg),
        .wdata(wr_data_reg),
        .re   (in_accept),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // read-stage payload
    logic               s1_btn_reg;
    logic [FIELD_W-1:0] s1_jx_reg;
    logic [FIELD_W-1:0] s1_jy_reg;

    // ---------------- block state ----------------
    logic [FIELD_W-1:0]        dead_low_reg, dead_low_next;
    logic [FIELD_W-1:0]        dead_high_reg, dead_high_next;
    logic                      mode_bit_reg, mode_bit_next;
    logic                      last_button_reg, last_button_next;
    logic signed [STEP_W-1:0]  last_step_reg, last_step_next;
    logic signed [THR_W-1:0]   thr_reg, thr_next;
    logic signed [CENTI_W-1:0] thr_centi_reg, thr_centi_next;
    logic                      alarm_bit_reg, alarm_bit_next;

    // output payload
    logic                      out_mode_reg;
    logic signed [THR_W-1:0]   out_thr_reg;
    logic                      out_alarm_reg;
    logic [CENTI_W-1:0]        out_centi_reg;

    logic signed [CENTI_W-1:0] centi;
    logic                      toggle;
    logic signed [STEP_W-1:0]  step_base;
    logic signed [STEP_W-1:0]  step;
    logic signed [THR_W:0]     thr_sum;
    logic signed [THR_W-1:0]   thr_sat;
    logic signed [CENTI_W-1:0] thr_mul;

    assign centi = $signed(ram_rdata);

    always_comb
    begin
        if (s1_jx_reg > dead_high_reg)
            step = STEP_UP_ONE;
        else if (s1_jx_reg < dead_low_reg)
            step = STEP_DOWN_ONE;
        else if (s1_jy_reg > dead_high_reg)
            step = STEP_DOWN_TEN;
        else if (s1_jy_reg < dead_low_reg)
            step = STEP_UP_TEN;
        else
            step = STEP_NONE;

        thr_sum = {thr_reg[THR_W-1], thr_reg} + (THR_W + 1)'(step);
        if (thr_sum < (THR_W + 1)'(THR_MIN))
            thr_sat = THR_MIN;
        else if (thr_sum > (THR_W + 1)'(THR_MAX))
            thr_sat = THR_MAX;
        else
            thr_sat = thr_sum[THR_W-1:0];
        thr_mul = CENTI_W'(thr_sat) * CENTI_PER_DEG;

        toggle    = s1_btn_reg && !last_button_reg;
        step_base = toggle ? STEP_NONE : last_step_reg;
    end

    always_comb
    begin
        fill_cnt_next    = fill_cnt_reg;
        wr_en_next       = fill_active;
        dead_low_next    = dead_low_reg;
        dead_high_next   = dead_high_reg;
        mode_bit_next    = mode_bit_reg;
        last_button_next = last_button_reg;
        last_step_next   = last_step_reg;
        thr_next         = thr_reg;
        thr_centi_next   = thr_centi_reg;
        alarm_bit_next   = alarm_bit_reg;
        s1_valid_next    = s1_valid_reg;
        m_valid_next     = m_valid_reg;

        if (fill_active)
            fill_cnt_next = fill_cnt_reg + 1'b1;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEAD_LOW:  dead_low_next  = cfg_data;
                REG_DEAD_HIGH: dead_high_next = cfg_data;
                default:       ;
            endcase
        end

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
            m_valid_next  = 1'b1;
        end
        if (in_accept)
            s1_valid_next = 1'b1;

        if (s1_adv)
        begin
            mode_bit_next    = mode_bit_reg ^ toggle;
            last_button_next = s1_btn_reg;
            last_step_next   = step_base;
            if (mode_bit_reg ^ toggle)
            begin
                if (step != STEP_NONE && step != step_base)
                begin
                    thr_next       = thr_sat;
                    thr_centi_next = thr_mul;
                    last_step_next = step;
                end
                else if (step == STEP_NONE)
                begin
                    last_step_next = STEP_NONE;
                end
            end
            else
            begin
                alarm_bit_next = (centi >= thr_centi_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg    <= '0;
            wr_en_reg       <= 1'b0;
            dead_low_reg    <= DEAD_LOW_RESET;
            dead_high_reg   <= DEAD_HIGH_RESET;
            mode_bit_reg    <= 1'b0;
            last_button_reg <= 1'b1;
            last_step_reg   <= STEP_NONE;
            thr_reg         <= THR_RESET;
            thr_centi_reg   <= THR_CENTI_RESET;
            alarm_bit_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            fill_cnt_reg    <= fill_cnt_next;
            wr_en_reg       <= wr_en_next;
            dead_low_reg    <= dead_low_next;
            dead_high_reg   <= dead_high_next;
            mode_bit_reg    <= mode_bit_next;
            last_button_reg <= last_button_next;
            last_step_reg   <= last_step_next;
            thr_reg         <= thr_next;
            thr_centi_reg   <= thr_centi_next;
            alarm_bit_reg   <= alarm_bit_next;
            s1_valid_reg    <= s1_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        wr_addr_reg <= fill_cnt_reg[ADC_BITS-1:0];
        wr_data_reg <= rom_table[fill_cnt_reg[ADC_BITS-1:0]];
        if (in_accept)
        begin
            s1_btn_reg <= in_button;
            s1_jx_reg  <= in_joy_x;
            s1_jy_reg  <= in_joy_y;
        end
        if (s1_adv)
        begin
            out_mode_reg  <= mode_bit_next;
            out_thr_reg   <= thr_next;
            out_alarm_reg <= alarm_bit_next;
            out_centi_reg <= ram_rdata;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, out_centi_reg, out_alarm_reg, out_thr_reg, out_mode_reg};

    // ---------------- checks ----------------
    logic thr_out_ok;
    logic step_ok;
    logic mon_update;

    assign thr_out_ok = (out_thr_reg >= THR_MIN) && (out_thr_reg <= THR_MAX);
    assign step_ok    = (last_step_reg == STEP_NONE) || (last_step_reg == STEP_UP_ONE)
                     || (last_step_reg == STEP_DOWN_ONE) || (last_step_reg == STEP_DOWN_TEN)
                     || (last_step_reg == STEP_UP_TEN);
    // an item leaving the read stage in monitor mode
    assign mon_update = s1_adv && !mode_bit_next;

    `OTA_ASSERT(a_thr_range, m_valid_reg |-> thr_out_ok, "threshold out of range")
    `OTA_ASSERT(a_alarm_monitor_only, $changed(alarm_bit_reg) |-> $past(mon_update), "alarm moved")
    `OTA_ASSERT_NEVER(a_fill_overlap, wr_en_reg && (s1_valid_reg || m_valid_reg), "load in use")
    `OTA_ASSERT(a_step_legal, step_ok, "illegal last step")

endmodule
